FILE: hdl/sale_pkg.sv
// Package with the types, sizes and command codes of the sorted array list engine.
package sale_pkg;

	localparam int DEPTH     = 128;
	localparam int PAYLOAD_W = 32;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int PFX_STEPS = $clog2(DEPTH);

	typedef enum logic [2:0] {
		CMD_APPEND       = 3'd0,
		CMD_INSERT_FRONT = 3'd1,
		CMD_INSERT_ORDER = 3'd2,
		CMD_REMOVE_LAST  = 3'd3,
		CMD_REMOVE_FIRST = 3'd4,
		CMD_REMOVE_KEY   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] entry_key;
		logic [31:0]        entry_payload;
	} req_t;

	typedef struct packed {
		logic       done_ok;
		logic [7:0] list_count;
		logic       list_empty;
		logic       list_full;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0]   key;
		logic [PAYLOAD_W-1:0] payload;
	} record_t;

	typedef struct packed {
		cell_op_t op;
		logic     ge;
		logic     ge_prev;
	} cell_ctrl_t;

endpackage

FILE: hdl/sale_cell.sv
// One list position: holds a record, compares it against the probe key and shifts.
module sale_cell (
	input  logic                clk,
	input  logic                capture,
	input  logic signed [31:0]  probe_key,
	input  sale_pkg::cell_ctrl_t ctrl,
	input  sale_pkg::record_t   new_rec,
	input  sale_pkg::record_t   left_rec,
	input  sale_pkg::record_t   right_rec,
	output sale_pkg::record_t   rec,
	output logic                lt,
	output logic                eq
);
	import sale_pkg::*;

	record_t rec_q;
	logic    lt_q;
	logic    eq_q;

	always_ff @(posedge clk) begin
		if (capture) begin
			lt_q <= rec_q.key < probe_key;
			eq_q <= rec_q.key == probe_key;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_INSERT && ctrl.ge) begin
			rec_q <= ctrl.ge_prev ? left_rec : new_rec;
		end else if (ctrl.op == OP_REMOVE && ctrl.ge) begin
			rec_q <= right_rec;
		end
	end

	assign rec = rec_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

FILE: hdl/sale_prefix.sv
// Prefix OR across the cell row, giving each cell whether a hit lies at or below it.
module sale_prefix (
	input  logic [sale_pkg::DEPTH-1:0] hit,
	output logic [sale_pkg::DEPTH-1:0] ge
);
	import sale_pkg::*;

	always_comb begin
		ge = hit;
		for (int s = 0; s < PFX_STEPS; s++) begin
			ge = ge | (ge << (1 << s));
		end
	end

endmodule

FILE: hdl/sorted_array_list_engine.sv
// Top level of the sorted array list engine: command sequencing and the row of cells.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (cmd, entry_key, entry_payload)
//   result  | rsp_valid | rsp_stall | rsp (done_ok, list_count, list_empty, list_full)
//
// Each command runs in order: the beat is taken and every cell compares its key,
// then the prefix across the cells places the insert or removal and the row shifts.
// A new request beat is taken in the cycle after a command completes.
// Reset clears the record count, the busy flag and the result valid; record contents stay undefined until written.
// A stalled result holds the command in its busy state until the output register frees.
module sorted_array_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sale_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sale_pkg::rsp_t rsp
);
	import sale_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [2:0]       cmd_s1;
	record_t          rec_s1;

	logic             accept;
	logic             finish;
	logic             ok;
	logic             is_full;
	logic             is_empty;
	logic [CNT_W-1:0] count_nxt;
	cell_op_t         op;
	record_t          new_rec;
	logic [63:0]      pay_ext;
	logic [31:0]      count_ext;

	logic [DEPTH-1:0] valid_v;
	logic [DEPTH-1:0] lt_v;
	logic [DEPTH-1:0] eq_v;
	logic [DEPTH-1:0] hit_v;
	logic [DEPTH-1:0] ge_v;
	record_t          cell_rec [DEPTH];

	assign accept    = req_valid && !req_stall;
	assign req_stall = busy_q;
	assign finish    = busy_q && (!rsp_valid_q || !rsp_stall);
	assign is_full   = count_q == CNT_W'(DEPTH);
	assign is_empty  = count_q == '0;

	always_comb begin
		pay_ext         = 64'(req.entry_payload);
		new_rec.key     = req.entry_key;
		new_rec.payload = pay_ext[PAYLOAD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.cmd;
			rec_s1 <= new_rec;
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid_v[i] = CNT_W'(i) < count_q;
		end
	end

	always_comb begin
		hit_v = '0;
		ok    = 1'b0;
		case (cmd_s1)
			CMD_APPEND: begin
				hit_v = ~valid_v;
				ok    = !is_full;
			end
			CMD_INSERT_FRONT: begin
				hit_v = '1;
				ok    = !is_full;
			end
			CMD_INSERT_ORDER: begin
				hit_v = ~valid_v | ~lt_v;
				ok    = !is_full;
			end
			CMD_REMOVE_LAST: begin
				ok = !is_empty;
			end
			CMD_REMOVE_FIRST: begin
				hit_v = '1;
				ok    = !is_empty;
			end
			CMD_REMOVE_KEY: begin
				hit_v = valid_v & eq_v;
				ok    = ge_v[DEPTH-1];
			end
			default: begin
				hit_v = '0;
				ok    = 1'b0;
			end
		endcase
	end

	sale_prefix u_prefix (
		.hit (hit_v),
		.ge  (ge_v)
	);

	always_comb begin
		op        = OP_HOLD;
		count_nxt = count_q;
		if (finish && ok) begin
			case (cmd_s1)
				CMD_APPEND, CMD_INSERT_FRONT, CMD_INSERT_ORDER: begin
					op        = OP_INSERT;
					count_nxt = count_q + 1'b1;
				end
				CMD_REMOVE_FIRST, CMD_REMOVE_KEY: begin
					op        = OP_REMOVE;
					count_nxt = count_q - 1'b1;
				end
				CMD_REMOVE_LAST: begin
					count_nxt = count_q - 1'b1;
				end
				default: begin
					op        = OP_HOLD;
					count_nxt = count_q;
				end
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		record_t    left_rec;
		record_t    right_rec;

		assign ctrl.op      = op;
		assign ctrl.ge      = ge_v[i];
		if (i == 0) begin : g_first
			assign ctrl.ge_prev = 1'b0;
			assign left_rec     = rec_s1;
		end else begin : g_mid
			assign ctrl.ge_prev = ge_v[i-1];
			assign left_rec     = cell_rec[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_rec = cell_rec[i];
		end else begin : g_inner
			assign right_rec = cell_rec[i+1];
		end

		sale_cell u_cell (
			.clk       (clk),
			.capture   (accept),
			.probe_key (req.entry_key),
			.ctrl      (ctrl),
			.new_rec   (rec_s1),
			.left_rec  (left_rec),
			.right_rec (right_rec),
			.rec       (cell_rec[i]),
			.lt        (lt_v[i]),
			.eq        (eq_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign count_ext = 32'(count_nxt);

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q.done_ok    <= ok;
			rsp_q.list_count <= count_ext[7:0];
			rsp_q.list_empty <= count_nxt == '0;
			rsp_q.list_full  <= count_nxt == CNT_W'(DEPTH);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("record count above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !accept)
		else $error("request taken while a command is in flight");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && ok && op == OP_INSERT) |=> count_q == $past(count_q) + 1'b1)
		else $error("successful insert did not grow the list");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.list_full && rsp.list_empty))
		else $error("list reported both full and empty");

endmodule

FILE: verif/sorted_array_list_engine_tb.sv
// Self-checking testbench for the sorted array list engine, with its own list predictor.
module sorted_array_list_engine_tb;
	import sale_pkg::*;

	localparam logic [2:0]         CMD_SPARE_A = 3'd6;
	localparam logic [2:0]         CMD_SPARE_B = 3'd7;
	localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX     = 32'sh7fff_ffff;
	localparam int                 PHASES      = 5;
	localparam int                 PHASE_LEN[PHASES]  = '{180, 180, 120, 150, 120};
	localparam int                 INSERT_PCT[PHASES] = '{95, 10, 55, 92, 10};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t        pending_cmds[$];
	rsp_t        expected_status[$];
	record_t     shadow_list[$];
	int unsigned cmds_taken  = 0;
	int unsigned status_seen = 0;
	int unsigned hold_left   = 0;
	bit          hold_used   = 1'b0;
	int unsigned mismatches  = 0;

	sorted_array_list_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d (result beat %0d)",
			$time, what, got, want, status_seen);
		mismatches++;
	endtask

	task automatic push_cmd(logic [2:0] code, logic signed [31:0] key, logic [31:0] payload);
		req_t beat;
		beat.cmd           = code;
		beat.entry_key     = key;
		beat.entry_payload = payload;
		pending_cmds.push_back(beat);
	endtask

	function automatic rsp_t apply_command(req_t beat);
		rsp_t    status;
		record_t rec;
		int      pos;
		logic    ok;
		ok          = 1'b0;
		pos         = 0;
		rec.key     = beat.entry_key;
		rec.payload = beat.entry_payload[PAYLOAD_W-1:0];
		case (beat.cmd)
			CMD_APPEND: begin
				if (shadow_list.size() < DEPTH) begin
					shadow_list.push_back(rec);
					ok = 1'b1;
				end
			end
			CMD_INSERT_FRONT: begin
				if (shadow_list.size() < DEPTH) begin
					shadow_list.push_front(rec);
					ok = 1'b1;
				end
			end
			CMD_INSERT_ORDER: begin
				if (shadow_list.size() < DEPTH) begin
					while (pos < shadow_list.size() &&
						$signed(shadow_list[pos].key) < $signed(beat.entry_key))
						pos++;
					shadow_list.insert(pos, rec);
					ok = 1'b1;
				end
			end
			CMD_REMOVE_LAST: begin
				if (shadow_list.size() != 0) begin
					void'(shadow_list.pop_back());
					ok = 1'b1;
				end
			end
			CMD_REMOVE_FIRST: begin
				if (shadow_list.size() != 0) begin
					void'(shadow_list.pop_front());
					ok = 1'b1;
				end
			end
			CMD_REMOVE_KEY: begin
				while (pos < shadow_list.size() && shadow_list[pos].key != beat.entry_key)
					pos++;
				if (pos < shadow_list.size()) begin
					shadow_list.delete(pos);
					ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		status.done_ok    = ok;
		status.list_count = 8'(shadow_list.size());
		status.list_empty = shadow_list.size() == 0;
		status.list_full  = shadow_list.size() == DEPTH;
		return status;
	endfunction

	always @(posedge clk) begin
		bit quiet;
		if (arst_n) begin
			quiet = cmds_taken >= 300 && cmds_taken < 450;
			if (req_valid && !req_stall) begin
				expected_status.push_back(apply_command(req));
				cmds_taken <= cmds_taken + 1;
			end
			if (!req_valid || !req_stall) begin
				if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
					req       <= pending_cmds.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// The single long hold-off lets the request side back up behind a full result register.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (!hold_used && status_seen >= 100) begin
			hold_used <= 1'b1;
			hold_left <= 80;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !(status_seen >= 300 && status_seen < 450) && $urandom_range(99) < 35;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			status_seen <= status_seen + 1;
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected beat, list_count", rsp.list_count, 8'd0);
			end else begin
				want = expected_status.pop_front();
				if (rsp.done_ok !== want.done_ok)
					report_mismatch("done_ok", 8'(rsp.done_ok), 8'(want.done_ok));
				if (rsp.list_count !== want.list_count)
					report_mismatch("list_count", rsp.list_count, want.list_count);
				if (rsp.list_empty !== want.list_empty)
					report_mismatch("list_empty", 8'(rsp.list_empty), 8'(want.list_empty));
				if (rsp.list_full !== want.list_full)
					report_mismatch("list_full", 8'(rsp.list_full), 8'(want.list_full));
			end
		end
	end

	initial begin
		int               roll;
		int               pick;
		logic [2:0]       code;
		logic signed [31:0] key;
		logic [31:0]      payload;

		push_cmd(CMD_REMOVE_LAST, 32'sd0, 32'h0);
		push_cmd(CMD_REMOVE_FIRST, 32'sd0, 32'h0);
		push_cmd(CMD_REMOVE_KEY, 32'sd0, 32'h0);
		push_cmd(CMD_SPARE_A, $urandom, $urandom);
		push_cmd(CMD_SPARE_B, $urandom, $urandom);
		push_cmd(CMD_APPEND, KEY_MAX, 32'hffff_ffff);
		push_cmd(CMD_INSERT_FRONT, KEY_MIN, 32'h0);
		push_cmd(CMD_INSERT_ORDER, 32'sd0, 32'h1234_5678);
		push_cmd(CMD_INSERT_ORDER, 32'sd0, 32'h8765_4321);
		push_cmd(CMD_INSERT_ORDER, KEY_MIN, 32'h0000_0001);
		push_cmd(CMD_INSERT_ORDER, KEY_MAX, 32'h8000_0000);
		push_cmd(CMD_REMOVE_KEY, 32'sd5, 32'h0);
		push_cmd(CMD_REMOVE_KEY, 32'sd0, 32'h0);
		push_cmd(CMD_REMOVE_FIRST, 32'sd0, 32'h0);
		push_cmd(CMD_REMOVE_LAST, 32'sd0, 32'h0);
		push_cmd(CMD_APPEND, -32'sd1, 32'h5555_5555);
		push_cmd(CMD_INSERT_FRONT, 32'sd1, 32'haaaa_aaaa);
		push_cmd(CMD_REMOVE_KEY, KEY_MAX, 32'h0);
		push_cmd(CMD_REMOVE_KEY, -32'sd1, 32'h0);
		push_cmd(CMD_REMOVE_KEY, KEY_MIN, 32'h0);

		// Phases alternate between filling past full and draining past empty, with a balanced phase in the middle.
		for (int phase = 0; phase < PHASES; phase++) begin
			for (int n = 0; n < PHASE_LEN[phase]; n++) begin
				roll = $urandom_range(99);
				if (roll < 3)
					code = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
				else if ($urandom_range(99) < INSERT_PCT[phase]) begin
					pick = $urandom_range(2);
					code = pick == 0 ? CMD_APPEND : pick == 1 ? CMD_INSERT_FRONT : CMD_INSERT_ORDER;
				end else begin
					pick = $urandom_range(3);
					code = pick == 0 ? CMD_REMOVE_LAST : pick == 1 ? CMD_REMOVE_FIRST : CMD_REMOVE_KEY;
				end
				roll = $urandom_range(99);
				if (roll < 8) begin
					pick = $urandom_range(3);
					key  = pick == 0 ? KEY_MIN : pick == 1 ? KEY_MAX : pick == 2 ? -32'sd1 : 32'sd0;
				end else if (roll < 75) begin
					key = $signed($urandom_range(15)) - 32'sd8;
				end else begin
					key = $urandom;
				end
				payload = $urandom;
				push_cmd(code, key, payload);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_cmds.size() != 0 || req_valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#400000;
		$display("[%0t] timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
